// ===== hw/rtl/lzwe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared types and constants of the LZW byte-stream encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned ALPHABET     = 256;
    localparam int unsigned EPOCH_W      = 4;
    localparam int unsigned MAX_RESULTS  = 4;
    localparam int unsigned PEND_MAX     = 7;
    localparam logic [31:0] HASH_MULT    = 32'h9E37_79B1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CMP,
        ST_DRAIN_MISS,
        ST_APPEND_LAST,
        ST_DRAIN_FLUSH,
        ST_END
    } lzwe_state_t;

    typedef struct packed {
        logic load;
        logic start_match;
        logic hash;
        logic probe_read;
        logic take_hit;
        logic miss;
        logic drain;
        logic flush;
        logic append_last;
        logic end_msg;
        logic clr_write;
    } lzwe_cmd_t;

    typedef struct packed {
        logic match_valid;
        logic last;
        logic hit;
        logic empty;
        logic exhausted;
        logic acc_ge8;
        logic acc_nonempty;
        logic out_free;
        logic clr_done;
        logic epoch_wrap;
    } lzwe_status_t;

endpackage

// ===== hw/rtl/lzw_byte_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_byte_stream_encoder
// LZW compressor with variable-width codes packed MSB first into bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                     | Marker
//  s_      | in        | tdata[7:0] = message byte   | tlast = final message byte
//  m_      | out       | tdata[7:0] = packed code bits | tlast = final padded byte
//
//  Steps: a byte that extends the match is accepted, hash-multiplied, read from
//  the table and compared; each extra collision probe adds a read and a compare
//  (one read port). A miss drains each emitted byte, then leaves the drain; the
//  final byte of a message adds append, drain of every byte, drain exit and message end.
//  Reset: a clearing pass over all HASH_SLOTS slots wipes the pair table with s_tready
//  low; the same pass runs after every 16th message.
//  Stalls: hold the drain while m_tvalid is high and m_tready is low.
// ----------------------------------------------------------------------------
module lzw_byte_stream_encoder #(
    parameter int unsigned MAX_CODES  = 4096,
    parameter int unsigned HASH_SLOTS = 8192
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import lzwe_pkg::*;

    lzwe_cmd_t    cmd;
    lzwe_status_t st;
    lzwe_state_t  state;

    // Sequencer: one transaction in flight at a time.
    lzwe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd),
        .state    (state)
    );

    // Dictionary, packer and output register.
    lzwe_datapath #(
        .MAX_CODES  (MAX_CODES),
        .HASH_SLOTS (HASH_SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    // No input taken while the table is being wiped.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // Output register is loaded only when it is free.
    a_drain_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drain |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // A hit ends the probe.
    a_hit_ends_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_CMP && st.hit) |=> (state == ST_IDLE || state == ST_APPEND_LAST))
        else $error("probe continued after hit");

endmodule

// ===== hw/rtl/lzwe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_ctrl
// Sequencer: input handshake, dictionary probe and output drain control.
// ----------------------------------------------------------------------------
module lzwe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    input  lzwe_pkg::lzwe_status_t st,
    output lzwe_pkg::lzwe_cmd_t    cmd,
    output lzwe_pkg::lzwe_state_t  state
);
    import lzwe_pkg::*;

    lzwe_state_t state_reg;
    lzwe_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (st.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (st.match_valid)  state_next = ST_HASH;
                    else if (s_tlast)    state_next = ST_APPEND_LAST;
                end
            end
            ST_HASH:  state_next = ST_READ;
            ST_READ:  state_next = ST_CMP;
            ST_CMP: begin
                if (st.hit)                         state_next = st.last ? ST_APPEND_LAST
                                                                        : ST_IDLE;
                else if (st.empty || st.exhausted)  state_next = ST_DRAIN_MISS;
                else                                state_next = ST_READ;
            end
            ST_DRAIN_MISS: begin
                if (!st.acc_ge8) state_next = st.last ? ST_APPEND_LAST : ST_IDLE;
            end
            ST_APPEND_LAST: state_next = ST_DRAIN_FLUSH;
            ST_DRAIN_FLUSH: begin
                if (!st.acc_nonempty) state_next = ST_END;
            end
            ST_END:  state_next = st.epoch_wrap ? ST_CLEAR : ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_write = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load        = 1'b1;
                    cmd.start_match = !st.match_valid;
                end
            end
            ST_HASH: cmd.hash       = 1'b1;
            ST_READ: cmd.probe_read = 1'b1;
            ST_CMP: begin
                if (st.hit)                         cmd.take_hit = 1'b1;
                else if (st.empty || st.exhausted)  cmd.miss     = 1'b1;
            end
            ST_DRAIN_MISS: cmd.drain = st.acc_ge8 && st.out_free;
            ST_APPEND_LAST: cmd.append_last = 1'b1;
            ST_DRAIN_FLUSH: begin
                cmd.flush = 1'b1;
                cmd.drain = st.acc_nonempty && st.out_free;
            end
            ST_END:  cmd.end_msg = 1'b1;
            default: cmd = '0;
        endcase
    end

    assign state = state_reg;

endmodule

// ===== hw/rtl/lzwe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_datapath
// Pair table, hash, match and code registers, bit packer and output register.
// ----------------------------------------------------------------------------
module lzwe_datapath #(
    parameter int unsigned MAX_CODES  = 4096,
    parameter int unsigned HASH_SLOTS = 8192
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  lzwe_pkg::lzwe_cmd_t    cmd,
    output lzwe_pkg::lzwe_status_t st
);
    import lzwe_pkg::*;

    localparam int unsigned CW   = $clog2(MAX_CODES);
    localparam int unsigned NW   = CW + 1;
    localparam int unsigned KW   = CW + BYTE_W;
    localparam int unsigned EW   = 1 + EPOCH_W + KW + CW;
    localparam int unsigned SW   = $clog2(HASH_SLOTS);
    localparam int unsigned TW   = SW + 1;
    localparam int unsigned WW   = $clog2(CW + 1);
    localparam int unsigned AW   = PEND_MAX + CW;
    localparam int unsigned CNTW = $clog2(AW + 1);
    localparam int unsigned RW   = $clog2(MAX_RESULTS + 1);

    logic [EW-1:0] mem [HASH_SLOTS];

    logic [7:0]         byte_reg,   byte_next;
    logic               last_reg,   last_next;
    logic [CW-1:0]      match_reg,  match_next;
    logic               mvalid_reg, mvalid_next;
    logic [NW-1:0]      free_reg,   free_next;
    logic [WW-1:0]      cw_reg,     cw_next;
    logic [AW-1:0]      acc_reg,    acc_next;
    logic [CNTW-1:0]    cnt_reg,    cnt_next;
    logic [RW-1:0]      n_reg,      n_next;
    logic [31:0]        mul_reg,    mul_next;
    logic [SW-1:0]      slot_reg,   slot_next;
    logic               first_reg,  first_next;
    logic [TW-1:0]      tries_reg,  tries_next;
    logic [EPOCH_W-1:0] epoch_reg,  epoch_next;
    logic [SW-1:0]      clr_reg,    clr_next;
    logic [7:0]         odata_reg,  odata_next;
    logic               olast_reg,  olast_next;
    logic               ovalid_reg, ovalid_next;
    logic [EW-1:0]      rd_reg;

    logic [KW-1:0]      key;
    logic [31:0]        mix;
    logic [SW-1:0]      rd_addr;
    logic               e_live;
    logic [EPOCH_W-1:0] e_epoch;
    logic [KW-1:0]      e_key;
    logic [CW-1:0]      e_code;
    logic               add_ok;
    logic [AW+7:0]      ext;
    logic               out_free;
    logic               fin;
    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;

    assign key     = {match_reg, byte_reg};
    assign mix     = mul_reg ^ (mul_reg >> 15);
    assign rd_addr = first_reg ? mix[SW-1:0] : slot_reg + SW'(1);
    assign e_epoch = rd_reg[EW-2 -: EPOCH_W];
    assign e_key   = rd_reg[CW +: KW];
    assign e_code  = rd_reg[CW-1:0];
    assign e_live  = rd_reg[EW-1] && (e_epoch == epoch_reg);
    assign add_ok  = !e_live && (free_reg < NW'(MAX_CODES))
                     && ((32'(free_reg) - 32'(ALPHABET)) < 32'(HASH_SLOTS));
    assign ext      = {acc_reg, 8'h00} >> cnt_reg;
    assign out_free = !ovalid_reg || m_tready;
    assign fin      = cmd.flush && ((cnt_reg <= CNTW'(8)) || (n_reg == RW'(MAX_RESULTS - 1)));

    assign wr_en   = cmd.clr_write || (cmd.miss && add_ok);
    assign wr_addr = cmd.clr_write ? clr_reg : slot_reg;
    assign wr_data = cmd.clr_write ? '0 : {1'b1, epoch_reg, key, free_reg[CW-1:0]};

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.probe_read) rd_reg <= mem[rd_addr];
    end

    always_comb begin
        byte_next   = byte_reg;
        last_next   = last_reg;
        match_next  = match_reg;
        mvalid_next = mvalid_reg;
        free_next   = free_reg;
        cw_next     = cw_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        mul_next    = mul_reg;
        slot_next   = slot_reg;
        first_next  = first_reg;
        tries_next  = tries_reg;
        epoch_next  = epoch_reg;
        clr_next    = clr_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !m_tready;

        if (cmd.clr_write) clr_next = clr_reg + SW'(1);
        if (cmd.load) begin
            byte_next = s_tdata;
            last_next = s_tlast;
            n_next    = '0;
        end
        if (cmd.start_match) begin
            match_next  = CW'(s_tdata);
            mvalid_next = 1'b1;
        end
        if (cmd.hash) begin
            mul_next   = 32'(32'(key) * HASH_MULT);
            first_next = 1'b1;
            tries_next = '0;
        end
        if (cmd.probe_read) begin
            slot_next  = rd_addr;
            first_next = 1'b0;
            tries_next = tries_reg + TW'(1);
        end
        if (cmd.take_hit) match_next = e_code;
        if (cmd.miss || cmd.append_last) begin
            acc_next = (acc_reg << cw_reg) | AW'(match_reg);
            cnt_next = cnt_reg + CNTW'(cw_reg);
        end
        if (cmd.miss) begin
            match_next = CW'(byte_reg);
            if (add_ok) begin
                free_next = free_reg + NW'(1);
                if (free_reg == (NW'(1) << cw_reg)) cw_next = cw_reg + WW'(1);
            end
        end
        if (cmd.drain) begin
            if (cnt_reg > CNTW'(8)) cnt_next = cnt_reg - CNTW'(8);
            else                    cnt_next = '0;
            if (n_reg < RW'(MAX_RESULTS)) begin
                n_next      = n_reg + RW'(1);
                odata_next  = ext[7:0];
                olast_next  = fin;
                ovalid_next = 1'b1;
            end
        end
        if (cmd.end_msg) begin
            mvalid_next = 1'b0;
            free_next   = NW'(ALPHABET);
            cw_next     = WW'(BYTE_W);
            cnt_next    = '0;
            epoch_next  = epoch_reg + EPOCH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
            free_reg   <= NW'(ALPHABET);
            cw_reg     <= WW'(BYTE_W);
            cnt_reg    <= '0;
            n_reg      <= '0;
            epoch_reg  <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            first_reg  <= 1'b0;
            tries_reg  <= '0;
        end else begin
            mvalid_reg <= mvalid_next;
            free_reg   <= free_next;
            cw_reg     <= cw_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            epoch_reg  <= epoch_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            first_reg  <= first_next;
            tries_reg  <= tries_next;
        end
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        match_reg <= match_next;
        acc_reg   <= acc_next;
        mul_reg   <= mul_next;
        slot_reg  <= slot_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tvalid = ovalid_reg;

    assign st.match_valid  = mvalid_reg;
    assign st.last         = last_reg;
    assign st.hit          = e_live && (e_key == key);
    assign st.empty        = !e_live;
    assign st.exhausted    = (tries_reg == TW'(HASH_SLOTS));
    assign st.acc_ge8      = (cnt_reg >= CNTW'(8));
    assign st.acc_nonempty = (cnt_reg != '0);
    assign st.out_free     = out_free;
    assign st.clr_done     = (clr_reg == '1);
    assign st.epoch_wrap   = (epoch_reg == '1);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lzw_byte_stream_encoder.
// ----------------------------------------------------------------------------
// Messages go in on the s_ channel and the packed code bytes are checked on
// the m_ channel against an LZW encoder written in the bench. Both channels
// idle at random. One longer message pushes the code width to ten bits, and
// many messages run back to back so that the periodic table clearing pass is
// crossed.
// ----------------------------------------------------------------------------
module testbench;
    import lzwe_pkg::*;

    localparam int unsigned DICT_LIMIT = 4096;
    localparam longint      CYCLE_CAP  = 64'd1_500_000;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    lzw_byte_stream_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // encoder state of the bench
    int unsigned phrase_dict[int unsigned];
    int unsigned cur_match;
    bit          have_match;
    int unsigned next_code;
    logic [7:0]  bit_acc;
    int unsigned bit_cnt;

    beat_t       byte_queue[$];    // message bytes not yet presented
    beat_t       packed_queue[$];  // code bytes the encoder owes us
    bit          calm;             // no idling while set
    int unsigned errors;
    longint      cycles;

    function automatic int unsigned width_for(int unsigned n);
        int unsigned w;
        w = 0;
        while ((1 << w) < n) w++;
        return w;
    endfunction

    function automatic void put_bits(int unsigned code, int unsigned w);
        beat_t b;
        for (int i = int'(w) - 1; i >= 0; i--) begin
            bit_acc = {bit_acc[6:0], code[i]};
            bit_cnt++;
            if (bit_cnt == 8) begin
                b.data = bit_acc;
                b.last = 1'b0;
                packed_queue.insert(packed_queue.size(), b);
                bit_acc = '0;
                bit_cnt = 0;
            end
        end
    endfunction

    function automatic void clear_dict();
        phrase_dict.delete();
        cur_match  = 0;
        have_match = 0;
        next_code  = ALPHABET;
        bit_acc    = '0;
        bit_cnt    = 0;
    endfunction

    // advance the encoder by one message byte
    function automatic void encode_byte(beat_t in);
        int unsigned key;
        beat_t       b;
        if (!have_match) begin
            cur_match  = in.data;
            have_match = 1;
        end else begin
            key = (cur_match << 8) | in.data;
            if (phrase_dict.exists(key)) begin
                cur_match = phrase_dict[key];
            end else begin
                put_bits(cur_match, width_for(next_code));
                if (next_code < DICT_LIMIT) begin
                    phrase_dict[key] = next_code;
                    next_code++;
                end
                cur_match = in.data;
            end
        end
        if (in.last) begin
            put_bits(cur_match, width_for(next_code));
            if (bit_cnt > 0) begin
                b.data = bit_acc << (8 - bit_cnt);
                b.last = 1'b0;
                packed_queue.insert(packed_queue.size(), b);
            end
            packed_queue[packed_queue.size() - 1].last = 1'b1;
            clear_dict();
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic add_message(int unsigned len, int unsigned span);
        beat_t b;
        for (int unsigned i = 0; i < len; i++) begin
            b.data = (span >= 256) ? 8'($urandom) : 8'($urandom_range(span - 1));
            b.last = (i == len - 1);
            byte_queue.insert(byte_queue.size(), b);
        end
    endtask

    task automatic add_fixed(input logic [7:0] v[$]);
        beat_t b;
        foreach (v[i]) begin
            b.data = v[i];
            b.last = (i == v.size() - 1);
            byte_queue.insert(byte_queue.size(), b);
        end
    endtask

    // driver: present queued bytes, with random gaps between transactions
    int unsigned tx_gap;
    always @(posedge aclk) begin
        beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                encode_byte('{last: s_tlast, data: s_tdata});
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    nxt = byte_queue.pop_front();
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                    tx_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, check each transaction against the owed bytes
    int unsigned rx_hold;
    always @(posedge aclk) begin
        beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (packed_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output byte %02h last %0b", m_tdata, m_tlast);
                end else begin
                    want = packed_queue.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %02h/%0b, got %02h/%0b",
                                     want.data, want.last, m_tdata, m_tlast);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_hold = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [7:0] v[$];
        int unsigned sent;
        errors = 0;
        cycles = 0;
        calm = 0;
        clear_dict();

        // directed: single bytes at both extremes, short runs and repeats
        v = '{8'h00};                         add_fixed(v);
        v = '{8'hFF};                         add_fixed(v);
        v = '{8'hA5, 8'h5A};                  add_fixed(v);
        v = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61}; add_fixed(v);
        v = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}; add_fixed(v);
        v = '{8'h55, 8'hAA, 8'h55};           add_fixed(v);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // longer message without idling: grow the code width to ten bits
        wait (byte_queue.size() == 0);
        calm = 1;
        add_message(300, 256);
        wait (byte_queue.size() == 0);
        calm = 0;

        // random short messages, mostly small alphabets so matches grow
        sent = 0;
        while (sent < 160) begin
            int unsigned len, span, r;
            len  = $urandom_range(16, 1);
            r    = $urandom_range(9);
            span = (r < 6) ? $urandom_range(4, 1) : ((r < 8) ? 16 : 256);
            calm = ($urandom_range(4) == 0);
            add_message(len, span);
            sent += len;
            wait (byte_queue.size() < 8);
        end

        wait (byte_queue.size() == 0 && !s_tvalid && packed_queue.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0 && packed_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
